// ===== hdl/hll_pkg.sv =====
// Shared types, constants and fixed-point helpers for the HLL flux cell update.
package hll_pkg;

    typedef struct packed {
        logic signed [31:0] depth;
        logic signed [31:0] momentum;
        logic signed [31:0] velocity;
        logic               starts_array;
    } cell_in_t;

    typedef struct packed {
        logic signed [31:0] new_depth;
        logic signed [31:0] new_momentum;
        logic               last_cell;
    } cell_out_t;

    localparam logic [2:0] REG_GRAVITY    = 3'd0;
    localparam logic [2:0] REG_INV_DX     = 3'd1;
    localparam logic [2:0] REG_DT_OVER_DX = 3'd2;
    localparam logic [2:0] REG_BOUNDARY   = 3'd3;
    localparam logic [2:0] REG_INTERIOR   = 3'd4;

    localparam logic signed [32:0] TWO_THIRDS_Q = 33'sd43691;
    localparam logic signed [32:0] HALF_Q       = 33'sd32768;
    localparam logic [31:0]        POS_LIMIT    = 32'h0FFF_FFFF;

    // Shared unit operations
    localparam logic [2:0] OP_MUL = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_SQRT = 3'd4;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } alu_cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -35'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

// ===== hdl/hll_flux_cell_update.sv =====
// Top level: control sequencer, window state and configuration of the HLL update.
// One cell is accepted, then a microcoded sequence runs every operation of the
// interface flux and cell update on the shared unit hll_alu. An interior cell
// needs 33 multiplies, 21 adds/subtracts, 2 roots, 2 divisions and the speed
// clamp step; the first interface forms only the flux, and a cell that only
// fills the window runs no operations. Ready is low while a cell is being worked
// on. A finished result waits in the output register while the next cell is
// taken; the sequencer holds its output step until that register is free.
module hll_flux_cell_update
#(
    parameter int MAX_INTERIOR_CELLS = 65536
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hll_pkg::cell_in_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hll_pkg::cell_out_t   out_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_DONE  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // Scratch register file slots
    localparam int NS = 32;
    localparam logic [4:0] R_HL = 5'd0, R_GL = 5'd1, R_UL = 5'd2, R_HR = 5'd3,
        R_GR = 5'd4, R_UR = 5'd5, R_PV = 5'd6, R_DUR = 5'd7, R_DUL = 5'd8,
        R_SL = 5'd9, R_SR = 5'd10, R_T0 = 5'd11, R_T1 = 5'd12, R_T2 = 5'd13,
        R_T3 = 5'd14, R_SLO = 5'd15, R_SRO = 5'd16, R_D = 5'd17, R_SLSR = 5'd18,
        R_NH = 5'd19, R_NG = 5'd20, R_FGL = 5'd21, R_FGR = 5'd22, R_FH = 5'd23,
        R_FG = 5'd24, R_LFH = 5'd25, R_LFG = 5'd26, R_ZERO = 5'd27,
        R_OH = 5'd28, R_OG = 5'd29;

    // Operand sources beyond the scratch file
    localparam logic [2:0] SRC_REG = 3'd0, SRC_GRAV = 3'd1, SRC_INVDX = 3'd2,
        SRC_DTDX = 3'd3, SRC_TWO3 = 3'd4, SRC_HALF = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] sa;
        logic [4:0] ra;
        logic [4:0] rb;
        logic [4:0] rd;
    } uop_t;

    function automatic uop_t mk(input logic [2:0] op, input logic [2:0] sa,
                                input logic [4:0] ra, input logic [4:0] rb,
                                input logic [4:0] rd);
        uop_t u;
        u.op = op; u.sa = sa; u.ra = ra; u.rb = rb; u.rd = rd;
        return u;
    endfunction

    // Microprogram; MIN/MAX/clamp and zero-divisor tests happen in the sequencer
    function automatic uop_t uprog(input logic [5:0] pc);
        uop_t u;
        case (pc)
            6'd0:  u = mk(hll_pkg::OP_SUB, SRC_REG, R_UR, R_UL, R_T0);
            6'd1:  u = mk(hll_pkg::OP_MUL, SRC_INVDX, R_ZERO, R_T0, R_DUR);
            6'd2:  u = mk(hll_pkg::OP_SUB, SRC_REG, R_UL, R_PV, R_T0);
            6'd3:  u = mk(hll_pkg::OP_MUL, SRC_INVDX, R_ZERO, R_T0, R_DUL);
            6'd4:  u = mk(hll_pkg::OP_MUL, SRC_GRAV, R_ZERO, R_HL, R_T0);
            6'd5:  u = mk(hll_pkg::OP_SQRT, SRC_REG, R_T0, R_ZERO, R_SL);
            6'd6:  u = mk(hll_pkg::OP_MUL, SRC_GRAV, R_ZERO, R_HR, R_T1);
            6'd7:  u = mk(hll_pkg::OP_SQRT, SRC_REG, R_T1, R_ZERO, R_SR);
            6'd8:  u = mk(hll_pkg::OP_SUB, SRC_REG, R_UL, R_SL, R_T0);
            6'd9:  u = mk(hll_pkg::OP_SUB, SRC_REG, R_UR, R_SR, R_T1);
            6'd10: u = mk(hll_pkg::OP_ADD, SRC_REG, R_UL, R_SL, R_T2);
            6'd11: u = mk(hll_pkg::OP_ADD, SRC_REG, R_UR, R_SR, R_T3);
            // pc 12: sequencer forms sl/sr from T0..T3 (no unit op)
            6'd12: u = mk(hll_pkg::OP_ADD, SRC_REG, R_ZERO, R_ZERO, R_ZERO);
            6'd13: u = mk(hll_pkg::OP_SUB, SRC_REG, R_SRO, R_SLO, R_D);
            6'd14: u = mk(hll_pkg::OP_MUL, SRC_REG, R_SLO, R_SRO, R_SLSR);
            6'd15: u = mk(hll_pkg::OP_MUL, SRC_REG, R_UL, R_HL, R_T0);
            6'd16: u = mk(hll_pkg::OP_MUL, SRC_REG, R_SRO, R_T0, R_T0);
            6'd17: u = mk(hll_pkg::OP_MUL, SRC_REG, R_UR, R_HR, R_T1);
            6'd18: u = mk(hll_pkg::OP_MUL, SRC_REG, R_SLO, R_T1, R_T1);
            6'd19: u = mk(hll_pkg::OP_SUB, SRC_REG, R_T0, R_T1, R_T0);
            6'd20: u = mk(hll_pkg::OP_SUB, SRC_REG, R_HR, R_HL, R_T1);
            6'd21: u = mk(hll_pkg::OP_MUL, SRC_REG, R_SLSR, R_T1, R_T1);
            6'd22: u = mk(hll_pkg::OP_ADD, SRC_REG, R_T0, R_T1, R_NH);
            // face flux G, left
            6'd23: u = mk(hll_pkg::OP_MUL, SRC_REG, R_HL, R_HL, R_T0);
            6'd24: u = mk(hll_pkg::OP_MUL, SRC_REG, R_T0, R_HL, R_T0);
            6'd25: u = mk(hll_pkg::OP_MUL, SRC_GRAV, R_ZERO, R_HL, R_T1);
            6'd26: u = mk(hll_pkg::OP_MUL, SRC_REG, R_T1, R_HL, R_T1);
            6'd27: u = mk(hll_pkg::OP_MUL, SRC_HALF, R_ZERO, R_T1, R_T1);
            6'd28: u = mk(hll_pkg::OP_MUL, SRC_TWO3, R_ZERO, R_T0, R_T0);
            6'd29: u = mk(hll_pkg::OP_MUL, SRC_REG, R_DUL, R_DUL, R_T2);
            6'd30: u = mk(hll_pkg::OP_MUL, SRC_REG, R_T0, R_T2, R_T0);
            6'd31: u = mk(hll_pkg::OP_MUL, SRC_REG, R_GL, R_UL, R_T2);
            6'd32: u = mk(hll_pkg::OP_ADD, SRC_REG, R_T2, R_T1, R_T2);
            6'd33: u = mk(hll_pkg::OP_SUB, SRC_REG, R_T2, R_T0, R_FGL);
            // face flux G, right
            6'd34: u = mk(hll_pkg::OP_MUL, SRC_REG, R_HR, R_HR, R_T0);
            6'd35: u = mk(hll_pkg::OP_MUL, SRC_REG, R_T0, R_HR, R_T0);
            6'd36: u = mk(hll_pkg::OP_MUL, SRC_GRAV, R_ZERO, R_HR, R_T1);
            6'd37: u = mk(hll_pkg::OP_MUL, SRC_REG, R_T1, R_HR, R_T1);
            6'd38: u = mk(hll_pkg::OP_MUL, SRC_HALF, R_ZERO, R_T1, R_T1);
            6'd39: u = mk(hll_pkg::OP_MUL, SRC_TWO3, R_ZERO, R_T0, R_T0);
            6'd40: u = mk(hll_pkg::OP_MUL, SRC_REG, R_DUR, R_DUR, R_T2);
            6'd41: u = mk(hll_pkg::OP_MUL, SRC_REG, R_T0, R_T2, R_T0);
            6'd42: u = mk(hll_pkg::OP_MUL, SRC_REG, R_GR, R_UR, R_T2);
            6'd43: u = mk(hll_pkg::OP_ADD, SRC_REG, R_T2, R_T1, R_T2);
            6'd44: u = mk(hll_pkg::OP_SUB, SRC_REG, R_T2, R_T0, R_FGR);
            6'd45: u = mk(hll_pkg::OP_MUL, SRC_REG, R_SRO, R_FGL, R_T0);
            6'd46: u = mk(hll_pkg::OP_MUL, SRC_REG, R_SLO, R_FGR, R_T1);
            6'd47: u = mk(hll_pkg::OP_SUB, SRC_REG, R_T0, R_T1, R_T0);
            6'd48: u = mk(hll_pkg::OP_SUB, SRC_REG, R_GR, R_GL, R_T1);
            6'd49: u = mk(hll_pkg::OP_MUL, SRC_REG, R_SLSR, R_T1, R_T1);
            6'd50: u = mk(hll_pkg::OP_ADD, SRC_REG, R_T0, R_T1, R_NG);
            6'd51: u = mk(hll_pkg::OP_DIV, SRC_REG, R_NH, R_D, R_FH);
            6'd52: u = mk(hll_pkg::OP_DIV, SRC_REG, R_NG, R_D, R_FG);
            // cell update (pc 53 is the branch point for storing only)
            6'd53: u = mk(hll_pkg::OP_SUB, SRC_REG, R_FH, R_LFH, R_T0);
            6'd54: u = mk(hll_pkg::OP_MUL, SRC_DTDX, R_ZERO, R_T0, R_T0);
            6'd55: u = mk(hll_pkg::OP_SUB, SRC_REG, R_HL, R_T0, R_OH);
            6'd56: u = mk(hll_pkg::OP_SUB, SRC_REG, R_FG, R_LFG, R_T1);
            6'd57: u = mk(hll_pkg::OP_MUL, SRC_DTDX, R_ZERO, R_T1, R_T1);
            6'd58: u = mk(hll_pkg::OP_SUB, SRC_REG, R_GL, R_T1, R_OG);
            default: u = mk(hll_pkg::OP_ADD, SRC_REG, R_ZERO, R_ZERO, R_ZERO);
        endcase
        return u;
    endfunction

    logic [31:0]          grav_reg, invdx_reg, dtdx_reg;
    logic [4:0]           nb_reg;
    logic [16:0]          ni_reg;
    logic [2:0]           state_reg, state_next;
    logic [5:0]           pc_reg, pc_next;
    logic [31:0]          pos_reg, pos_next;
    logic                 emit_reg, emit_next;
    logic                 first_reg, first_next;
    logic                 last_reg, last_next;
    logic signed [31:0]   rf_reg [NS];
    logic signed [31:0]   prev_u_reg, held_h_reg, held_g_reg, held_u_reg;
    logic signed [31:0]   lfh_reg, lfg_reg;
    hll_pkg::cell_out_t   out_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_load;
    hll_pkg::alu_cmd_t    cmd;
    logic signed [32:0]   opa, opb;
    logic                 alu_done;
    logic signed [31:0]   alu_res;
    uop_t                 uop;
    logic [31:0]          pos_in;
    logic [31:0]          nb_eff;
    logic [31:0]          ni_eff;
    logic                 in_fire;
    logic signed [31:0]   mn, mx;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign uop = uprog(pc_reg);
    // load the output register once it is empty or being drained
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    assign pos_in = in_data.starts_array ? 32'd0 : pos_reg;
    assign nb_eff = (nb_reg == 5'd0) ? 32'd1 : 32'(nb_reg);
    always_comb
    begin
        ni_eff = (ni_reg == 17'd0) ? 32'd1 : 32'(ni_reg);
        if (ni_eff > 32'(MAX_INTERIOR_CELLS))
            ni_eff = 32'(MAX_INTERIOR_CELLS);
    end

    always_comb
    begin
        case (uop.sa)
            SRC_GRAV:  opa = 33'($unsigned(grav_reg));
            SRC_INVDX: opa = 33'($unsigned(invdx_reg));
            SRC_DTDX:  opa = 33'($unsigned(dtdx_reg));
            SRC_TWO3:  opa = hll_pkg::TWO_THIRDS_Q;
            SRC_HALF:  opa = hll_pkg::HALF_Q;
            default:   opa = 33'(rf_reg[uop.ra]);
        endcase
        opb = 33'(rf_reg[uop.rb]);
    end

    assign cmd.start = (state_reg == ST_ISSUE) && (pc_reg != 6'd12);
    assign cmd.op = uop.op;

    hll_alu u_alu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .a      (opa),
        .b      (opb),
        .done   (alu_done),
        .result (alu_res)
    );

    assign mn = (rf_reg[R_T0] < rf_reg[R_T1]) ? rf_reg[R_T0] : rf_reg[R_T1];
    assign mx = (rf_reg[R_T2] > rf_reg[R_T3]) ? rf_reg[R_T2] : rf_reg[R_T3];

    always_comb
    begin
        state_next = state_reg;
        pc_next = pc_reg;
        pos_next = pos_reg;
        emit_next = emit_reg;
        first_next = first_reg;
        last_next = last_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pos_next = (pos_in < hll_pkg::POS_LIMIT) ? pos_in + 32'd1
                                                             : hll_pkg::POS_LIMIT;
                    if (pos_in >= nb_eff && pos_in <= nb_eff + ni_eff)
                    begin
                        state_next = ST_ISSUE;
                        pc_next = 6'd0;
                        first_next = (pos_in == nb_eff);
                        emit_next = (pos_in > nb_eff);
                        last_next = (pos_in == nb_eff + ni_eff);
                    end
                    else
                        state_next = ST_DONE;
                end
            end
            ST_ISSUE:
            begin
                if (pc_reg == 6'd12)
                    pc_next = 6'd13;
                else if (pc_reg == 6'd2 && first_reg)
                    pc_next = 6'd4;
                else
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = ST_ISSUE;
                    pc_next = pc_reg + 6'd1;
                    // zero divisor: flux is zero, skip to the update
                    if (pc_reg == 6'd13 && alu_res == 32'sd0)
                        pc_next = 6'd53;
                    if (pc_reg == 6'd52 || (pc_reg == 6'd13 && alu_res == 32'sd0))
                    begin
                        if (!emit_reg)
                            state_next = ST_DONE;
                    end
                    if (pc_reg == 6'd58)
                        state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the previous result leaves
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg <= 32'd642908;
            invdx_reg <= 32'd65536;
            dtdx_reg <= 32'd6554;
            nb_reg <= 5'd3;
            ni_reg <= 17'd1024;
            state_reg <= ST_IDLE;
            pc_reg <= '0;
            pos_reg <= '0;
            emit_reg <= 1'b0;
            first_reg <= 1'b0;
            last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_u_reg <= '0;
            held_h_reg <= '0;
            held_g_reg <= '0;
            held_u_reg <= '0;
            lfh_reg <= '0;
            lfg_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    hll_pkg::REG_GRAVITY:    grav_reg <= cfg_data;
                    hll_pkg::REG_INV_DX:     invdx_reg <= cfg_data;
                    hll_pkg::REG_DT_OVER_DX: dtdx_reg <= cfg_data;
                    hll_pkg::REG_BOUNDARY:   nb_reg <= cfg_data[4:0];
                    hll_pkg::REG_INTERIOR:   ni_reg <= cfg_data[16:0];
                    default: ;
                endcase
            end
            state_reg <= state_next;
            pc_reg <= pc_next;
            pos_reg <= pos_next;
            emit_reg <= emit_next;
            first_reg <= first_next;
            last_reg <= last_next;
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                prev_u_reg <= held_u_reg;
                held_h_reg <= in_data.depth;
                held_g_reg <= in_data.momentum;
                held_u_reg <= in_data.velocity;
            end
            // store fluxes once formed (or zeroed)
            if (state_reg == ST_WAIT && alu_done && pc_reg == 6'd52)
            begin
                lfh_reg <= rf_reg[R_FH];
                lfg_reg <= alu_res;
            end
            else if (state_reg == ST_WAIT && alu_done && pc_reg == 6'd13
                     && alu_res == 32'sd0)
            begin
                lfh_reg <= '0;
                lfg_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            // window: left = held cell, right = incoming
            rf_reg[R_HL] <= held_h_reg;
            rf_reg[R_GL] <= held_g_reg;
            rf_reg[R_UL] <= held_u_reg;
            rf_reg[R_PV] <= prev_u_reg;
            rf_reg[R_HR] <= in_data.depth;
            rf_reg[R_GR] <= in_data.momentum;
            rf_reg[R_UR] <= in_data.velocity;
            rf_reg[R_ZERO] <= '0;
            rf_reg[R_LFH] <= lfh_reg;
            rf_reg[R_LFG] <= lfg_reg;
        end
        else if (state_reg == ST_ISSUE && pc_reg == 6'd12)
        begin
            rf_reg[R_SLO] <= (mn > 32'sd0) ? 32'sd0 : mn;
            rf_reg[R_SRO] <= (mx < 32'sd0) ? 32'sd0 : mx;
        end
        else if (state_reg == ST_WAIT && alu_done)
        begin
            rf_reg[uop.rd] <= alu_res;
            if (pc_reg == 6'd1 && first_reg)
                rf_reg[R_DUL] <= alu_res;
            if (pc_reg == 6'd13 && alu_res == 32'sd0)
            begin
                rf_reg[R_FH] <= '0;
                rf_reg[R_FG] <= '0;
            end
        end
        if (out_load)
        begin
            out_reg.new_depth <= rf_reg[R_OH];
            out_reg.new_momentum <= rf_reg[R_OG];
            out_reg.last_cell <= last_reg;
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready) else $error("ready while busy");
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT) else $error("stray result");
    a_emit_has_flux: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> emit_reg) else $error("result for boundary interface");

endmodule

// ===== hdl/hll_alu.sv =====
// Shared unit: saturating add/sub, rounded Q16.16 multiply, divide and square root.
module hll_alu
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hll_pkg::alu_cmd_t    cmd,
    input  logic signed [32:0]   a,
    input  logic signed [32:0]   b,
    output logic                 done,
    output logic signed [31:0]   result
);

    logic               busy_reg, busy_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [2:0]         op_reg, op_next;
    logic               neg_reg, neg_next;
    logic [63:0]        acc_reg, acc_next;
    logic [63:0]        rem_reg, rem_next;
    logic [32:0]        den_reg, den_next;
    logic [63:0]        prod;
    logic [64:0]        trial;
    logic [32:0]        mag_a, mag_b;
    logic [33:0]        mag_r;
    logic               done_reg, done_next;
    logic signed [31:0] result_reg, result_next;

    assign mag_a = a[32] ? 33'(-a) : 33'(a);
    assign mag_b = b[32] ? 33'(-b) : 33'(b);
    assign done = done_reg;
    assign result = result_reg;

    // One 32x32 product per cycle (unsigned magnitudes; operands stay below 2^32)
    assign prod = 64'(mag_a[31:0]) * 64'(mag_b[31:0]);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        op_next = op_reg;
        neg_next = neg_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        done_next = 1'b0;
        result_next = result_reg;
        trial = '0;
        mag_r = '0;
        if (cmd.start)
        begin
            op_next = cmd.op;
            neg_next = a[32] ^ b[32];
            case (cmd.op)
                hll_pkg::OP_MUL:
                begin
                    // magnitude of an operand may reach 2^32 only for -2^32, not used
                    acc_next = prod + 64'd32768;
                    busy_next = 1'b1;
                    cnt_next = 6'd0;
                end
                hll_pkg::OP_ADD:
                begin
                    result_next = hll_pkg::sat32(35'(a) + 35'(b));
                    done_next = 1'b1;
                end
                hll_pkg::OP_SUB:
                begin
                    result_next = hll_pkg::sat32(35'(a) - 35'(b));
                    done_next = 1'b1;
                end
                hll_pkg::OP_DIV:
                begin
                    neg_next = a[32];
                    // numerator scaled by 2^16 plus half the divisor
                    rem_next = {mag_a[31:0], 16'd0} + 64'(mag_b[32:1]);
                    den_next = mag_b;
                    acc_next = '0;
                    cnt_next = 6'd48;
                    busy_next = 1'b1;
                end
                hll_pkg::OP_SQRT:
                begin
                    neg_next = 1'b0;
                    if (a <= 0)
                    begin
                        result_next = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rem_next = {16'd0, a[31:0], 16'd0};
                        acc_next = '0;
                        cnt_next = 6'd24;
                        busy_next = 1'b1;
                    end
                end
                default:
                begin
                    done_next = 1'b1;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                hll_pkg::OP_MUL:
                begin
                    mag_r = (acc_reg[63:16] > 48'h1_0000_0000) ? 34'h1_0000_0000
                                                                : acc_reg[49:16];
                    result_next = hll_pkg::sat32(neg_reg ? -35'(mag_r) : 35'(mag_r));
                    done_next = 1'b1;
                    busy_next = 1'b0;
                end
                hll_pkg::OP_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    trial = 65'(rem_reg >> (cnt_reg - 6'd1));
                    if (trial >= 65'(den_reg))
                    begin
                        rem_next = rem_reg - (64'(den_reg) << (cnt_reg - 6'd1));
                        acc_next = {acc_reg[62:0], 1'b1};
                    end
                    else
                        acc_next = {acc_reg[62:0], 1'b0};
                    cnt_next = cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        mag_r = (acc_next > 64'h1_0000_0000) ? 34'h1_0000_0000
                                                             : acc_next[33:0];
                        result_next = hll_pkg::sat32(neg_reg ? -35'(mag_r)
                                                             : 35'(mag_r));
                    end
                end
                hll_pkg::OP_SQRT:
                begin
                    // digit-by-digit root, one result bit per cycle
                    trial = 65'({acc_reg[61:0], 2'b01}) << ((cnt_reg - 6'd1) * 2);
                    if (65'(rem_reg) >= trial)
                    begin
                        rem_next = rem_reg - trial[63:0];
                        acc_next = {acc_reg[62:0], 1'b1};
                    end
                    else
                        acc_next = {acc_reg[62:0], 1'b0};
                    cnt_next = cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        result_next = acc_next[31:0];
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= hll_pkg::OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        result_reg <= result_next;
    end

    a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !cmd.start) else $error("command issued while unit busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg || $past(cmd.start)) else $error("done held");
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cmd.start) || $past(busy_reg)) else $error("spurious done");

endmodule
